[rtl/xcc_pkg.sv]
// Shared types, constants and helpers for the XChaCha20 stream cipher core.
package xcc_pkg;

    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int DOUBLE_ROUNDS = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_0 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_1 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_2 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_CTR = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HCHACHA,
        ST_LOAD_BLOCK,
        ST_BLOCK,
        ST_ADD,
        ST_OUT
    } state_t;

    // One quarter-round step: a += b; d = rotl(d ^ a, s)
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [1:0]  rot_sel;
    } qr_in_t;

    typedef struct packed {
        logic [31:0] sum;
        logic [31:0] mix;
    } qr_out_t;

    // Quarter-round index sets: column rounds then diagonal rounds
    function automatic logic [15:0] qr_idx(input logic [2:0] q);
        logic [15:0] r;
        case (q)
            3'd0: r = {4'd0, 4'd4, 4'd8,  4'd12};
            3'd1: r = {4'd1, 4'd5, 4'd9,  4'd13};
            3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
            3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
            3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
            3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
            3'd6: r = {4'd2, 4'd7, 4'd8,  4'd13};
            default: r = {4'd3, 4'd4, 4'd9, 4'd14};
        endcase
        return r;
    endfunction

endpackage

[rtl/xcc_qr_unit.sv]
// Shared add, xor and rotate unit: one quarter-round step per cycle.
module xcc_qr_unit (
    input  xcc_pkg::qr_in_t  op,
    input  logic [31:0]      d,
    output xcc_pkg::qr_out_t res
);
    logic [31:0] s;
    logic [31:0] x;

    always_comb
    begin
        s = op.a + op.b;
        x = d ^ s;
        res.sum = s;
        case (op.rot_sel)
            2'd0: res.mix = {x[15:0], x[31:16]};
            2'd1: res.mix = {x[19:0], x[31:20]};
            2'd2: res.mix = {x[23:0], x[31:24]};
            default: res.mix = {x[24:0], x[31:25]};
        endcase
    end
endmodule

[rtl/xchacha20_stream_cipher_core.sv]
// Top level of the XChaCha20 stream cipher core.
// Usage:
//  Input channel (in_valid/in_stall, data, byte_count, last) takes one
//  8-byte request; output channel (out_valid/out_stall, result,
//  valid_bytes, end_of_message) returns one result per request.
//  Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//  the user must keep to that, as the block itself does not enforce it.
//  The first request of a message first runs HChaCha20: 80 quarter-rounds
//  of 4 steps. A request that opens a 64-byte block (the first and every
//  eighth after it) then runs the block load, 320 round steps, the add of
//  the 16 state words and the output step. Other requests go from idle
//  straight to the output step. A long message's rate is set by the
//  single shared quarter-round unit doing one of its 4 steps per cycle.
//  A result is held in the output register while out_stall is high; the
//  next request is taken only once it has left.
//  Reset clears control, key, nonce and subkey; initial_counter resets to 1.
module xchacha20_stream_cipher_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [xcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [xcc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [63:0]                      data,
    input  logic [3:0]                       byte_count,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      result,
    output logic [3:0]                       valid_bytes,
    output logic                             end_of_message
);
    xcc_pkg::state_t state_reg, state_next;
    logic [63:0] key_reg [4];
    logic [63:0] nonce_reg [3];
    logic [31:0] init_ctr_reg;
    logic [31:0] subkey_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] ks_reg [16];
    logic [31:0] ctr_reg;
    logic [2:0]  wp_reg;
    logic        in_msg_reg;
    logic [2:0]  qr_reg;
    logic [1:0]  step_reg;
    logic [3:0]  dr_reg;
    logic [3:0]  add_reg;
    logic [63:0] data_reg;
    logic [3:0]  cnt_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [63:0] result_reg;
    logic [3:0]  vb_reg;
    logic        eom_reg;

    logic [15:0] idx;
    logic [3:0]  ia, ib, ic, id, dst_s, dst_m, src_x;
    xcc_pkg::qr_in_t  op;
    xcc_pkg::qr_out_t res;
    logic [31:0] dval;
    logic        accept;
    logic        round_done;
    logic [3:0]  cnt_eff;
    logic [63:0] mask;
    logic [63:0] ks;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != xcc_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign result = result_reg;
    assign valid_bytes = vb_reg;
    assign end_of_message = eom_reg;

    assign idx = xcc_pkg::qr_idx(qr_reg);
    assign ia = idx[15:12];
    assign ib = idx[11:8];
    assign ic = idx[7:4];
    assign id = idx[3:0];

    // Steps: 0 a+=b,d^=a; 1 c+=d,b^=c; 2 a+=b,d^=a; 3 c+=d,b^=c
    always_comb
    begin
        if (step_reg[0])
        begin
            dst_s = ic;
            dst_m = ib;
            src_x = id;
        end
        else
        begin
            dst_s = ia;
            dst_m = id;
            src_x = ib;
        end
        op.a = w_reg[dst_s];
        op.b = w_reg[src_x];
        op.rot_sel = step_reg;
        dval = w_reg[dst_m];
    end

    xcc_qr_unit u_qr (
        .op  (op),
        .d   (dval),
        .res (res)
    );

    assign round_done = (step_reg == 2'd3) && (qr_reg == 3'd7)
        && (dr_reg == 4'(xcc_pkg::DOUBLE_ROUNDS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xcc_pkg::ST_IDLE:
                if (accept)
                begin
                    if (!in_msg_reg)
                        state_next = xcc_pkg::ST_HCHACHA;
                    else if (wp_reg == 3'd0)
                        state_next = xcc_pkg::ST_LOAD_BLOCK;
                    else
                        state_next = xcc_pkg::ST_OUT;
                end
            xcc_pkg::ST_HCHACHA:
                if (round_done)
                    state_next = xcc_pkg::ST_LOAD_BLOCK;
            xcc_pkg::ST_LOAD_BLOCK:
                state_next = xcc_pkg::ST_BLOCK;
            xcc_pkg::ST_BLOCK:
                if (round_done)
                    state_next = xcc_pkg::ST_ADD;
            xcc_pkg::ST_ADD:
                if (add_reg == 4'd15)
                    state_next = xcc_pkg::ST_OUT;
            xcc_pkg::ST_OUT:
                state_next = xcc_pkg::ST_IDLE;
            default:
                state_next = xcc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (!last_reg || cnt_reg > 4'd8)
            cnt_eff = 4'd8;
        else if (cnt_reg == 4'd0)
            cnt_eff = 4'd1;
        else
            cnt_eff = cnt_reg;
        for (int i = 0; i < 8; i++)
            mask[i*8 +: 8] = (4'(i) < cnt_eff) ? 8'hff : 8'h00;
        ks = {ks_reg[{wp_reg, 1'b1}], ks_reg[{wp_reg, 1'b0}]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xcc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            in_msg_reg <= 1'b0;
            wp_reg <= 3'd0;
            ctr_reg <= 32'd0;
            init_ctr_reg <= 32'd1;
            qr_reg <= 3'd0;
            step_reg <= 2'd0;
            dr_reg <= 4'd0;
            add_reg <= 4'd0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= 64'd0;
            for (int i = 0; i < 3; i++)
                nonce_reg[i] <= 64'd0;
            for (int i = 0; i < 8; i++)
                subkey_reg[i] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    xcc_pkg::REG_KEY_0: key_reg[0] <= cfg_data;
                    xcc_pkg::REG_KEY_1: key_reg[1] <= cfg_data;
                    xcc_pkg::REG_KEY_2: key_reg[2] <= cfg_data;
                    xcc_pkg::REG_KEY_3: key_reg[3] <= cfg_data;
                    xcc_pkg::REG_NONCE_0: nonce_reg[0] <= cfg_data;
                    xcc_pkg::REG_NONCE_1: nonce_reg[1] <= cfg_data;
                    xcc_pkg::REG_NONCE_2: nonce_reg[2] <= cfg_data;
                    xcc_pkg::REG_INIT_CTR: init_ctr_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
            case (state_reg)
                xcc_pkg::ST_IDLE:
                    if (accept && !in_msg_reg)
                    begin
                        in_msg_reg <= 1'b1;
                        wp_reg <= 3'd0;
                        ctr_reg <= init_ctr_reg;
                    end
                xcc_pkg::ST_HCHACHA, xcc_pkg::ST_BLOCK:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        qr_reg <= qr_reg + 3'd1;
                        if (qr_reg == 3'd7)
                            dr_reg <= round_done ? 4'd0 : dr_reg + 4'd1;
                    end
                    // The final step writes words 4 and 9 only; the kept words are final
                    if (round_done && state_reg == xcc_pkg::ST_HCHACHA)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            subkey_reg[i] <= w_reg[i];
                            subkey_reg[4+i] <= w_reg[12+i];
                        end
                    end
                end
                xcc_pkg::ST_LOAD_BLOCK:
                    ctr_reg <= ctr_reg + 32'd1;
                xcc_pkg::ST_ADD:
                    add_reg <= add_reg + 4'd1;
                xcc_pkg::ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    if (last_reg)
                    begin
                        in_msg_reg <= 1'b0;
                        wp_reg <= 3'd0;
                    end
                    else
                        wp_reg <= wp_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    // Payload: round words, keystream, captured request and result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            xcc_pkg::ST_IDLE:
                if (accept)
                begin
                    data_reg <= data;
                    cnt_reg <= byte_count;
                    last_reg <= last;
                    if (!in_msg_reg)
                    begin
                        w_reg[0] <= xcc_pkg::SIGMA_0;
                        w_reg[1] <= xcc_pkg::SIGMA_1;
                        w_reg[2] <= xcc_pkg::SIGMA_2;
                        w_reg[3] <= xcc_pkg::SIGMA_3;
                        for (int i = 0; i < 4; i++)
                        begin
                            w_reg[4+2*i] <= key_reg[i][31:0];
                            w_reg[5+2*i] <= key_reg[i][63:32];
                        end
                        w_reg[12] <= nonce_reg[0][31:0];
                        w_reg[13] <= nonce_reg[0][63:32];
                        w_reg[14] <= nonce_reg[1][31:0];
                        w_reg[15] <= nonce_reg[1][63:32];
                    end
                end
            xcc_pkg::ST_HCHACHA, xcc_pkg::ST_BLOCK:
            begin
                w_reg[dst_s] <= res.sum;
                w_reg[dst_m] <= res.mix;
            end
            xcc_pkg::ST_LOAD_BLOCK:
            begin
                w_reg[0] <= xcc_pkg::SIGMA_0;
                w_reg[1] <= xcc_pkg::SIGMA_1;
                w_reg[2] <= xcc_pkg::SIGMA_2;
                w_reg[3] <= xcc_pkg::SIGMA_3;
                for (int i = 0; i < 8; i++)
                    w_reg[4+i] <= subkey_reg[i];
                w_reg[12] <= ctr_reg;
                w_reg[13] <= 32'd0;
                w_reg[14] <= nonce_reg[2][31:0];
                w_reg[15] <= nonce_reg[2][63:32];
                ks_reg[0] <= xcc_pkg::SIGMA_0;
                ks_reg[1] <= xcc_pkg::SIGMA_1;
                ks_reg[2] <= xcc_pkg::SIGMA_2;
                ks_reg[3] <= xcc_pkg::SIGMA_3;
                for (int i = 0; i < 8; i++)
                    ks_reg[4+i] <= subkey_reg[i];
                ks_reg[12] <= ctr_reg;
                ks_reg[13] <= 32'd0;
                ks_reg[14] <= nonce_reg[2][31:0];
                ks_reg[15] <= nonce_reg[2][63:32];
            end
            xcc_pkg::ST_ADD:
                ks_reg[add_reg] <= ks_reg[add_reg] + w_reg[add_reg];
            xcc_pkg::ST_OUT:
            begin
                result_reg <= (data_reg ^ ks) & mask;
                vb_reg <= cnt_eff;
                eom_reg <= last_reg;
            end
            default: ;
        endcase
    end

    // Requests are stalled outside the idle state; the shared unit never runs while a result still waits
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != xcc_pkg::ST_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");
    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (valid_bytes != 4'd0 && valid_bytes <= 4'd8))
        else $error("valid_bytes out of range");
    a_out_after_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == xcc_pkg::ST_OUT)
        else $error("result raised outside output step");
endmodule
